>>> src/p2rgb_pkg.sv
package p2rgb_pkg;

    // Widths of the item fields and of the configuration port.
    localparam int unsigned CompWidth  = 16;
    localparam int unsigned ChanWidth  = 8;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned CfgDataWidth = 16;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] REG_COMPONENT_FORMAT = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_COMP_COUNT       = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_ROW_WIDTH        = 2'd2;

    // Component count codes that select a special path; all others pass through.
    localparam logic [2:0] COUNT_GREY = 3'd1;
    localparam logic [2:0] COUNT_RG   = 3'd2;
    localparam logic [2:0] COUNT_RGBA = 3'd4;

    // Reset values of the configuration registers.
    localparam logic       FORMAT_RESET    = 1'b0;
    localparam logic [2:0] COUNT_RESET     = 3'd3;
    localparam logic [15:0] ROW_WIDTH_RESET = 16'd1;

    // Q0.17 checkerboard weights per color, held in 16 bits.
    localparam logic [15:0] K_RED   = 16'd20316;
    localparam logic [15:0] K_GREEN = 16'd34734;
    localparam logic [15:0] K_BLUE  = 16'd33423;

    // floor(v/257) for 16-bit v equals (v * 65281) >> 24.
    localparam logic [16:0] RECIP_257 = 17'd65281;
    // floor(m/255) for m below 132626 equals (m * 131587) >> 25.
    localparam logic [17:0] RECIP_255 = 18'd131587;

    typedef struct packed {
        logic [15:0] comp0;
        logic [15:0] comp1;
        logic [15:0] comp2;
        logic [15:0] comp3;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       row_end;
    } pix_out_t;

    // Side information that travels alongside a pixel through the pipeline.
    typedef struct packed {
        logic parity;
        logic row_end;
    } pix_tag_t;

endpackage

>>> src/pixel_to_rgb8_with_checker_alpha.sv
// Pixel to RGB8 converter with checkerboard alpha compositing.
// The s_ channel carries one pixel per request (four components, of which the
// configured count is used); the m_ channel returns one RGB8 pixel per request
// together with a flag that marks the last pixel of a row.
// The cfg_ channel writes the component format (index 0), the component count
// (index 1) and the row width (index 2); it is always ready, and writes are
// meant to happen only while no pixel is in flight. Unknown indexes are ignored.
// An accepted pixel passes the scale lane registers, then the blend sums and
// stage 2 copies, then the merge register, whose output is m_data with m_valid
// high. Throughput is one pixel per clock while m_ready keeps up: four scale
// lanes, three blend lanes and a merge register each take a new pixel every cycle.
// A synchronous low aresetn empties the pipeline, restores the register
// defaults and puts the checkerboard position at the start of an even row.
// When the receiver stalls the whole pipeline holds, and s_ready drops once
// the output register is full and m_ready is low, so nothing is lost.
module pixel_to_rgb8_with_checker_alpha (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  p2rgb_pkg::pix_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output p2rgb_pkg::pix_out_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    // Configuration registers.
    logic        format_reg;
    logic [2:0]  count_reg;
    logic [15:0] row_width_reg;

    // Checkerboard position.
    logic [15:0] column_reg;
    logic [15:0] column_next;
    logic        parity_reg;
    logic        parity_next;
    logic [15:0] last_col;
    logic        at_row_end;

    // Pipeline control.
    logic     adv;
    logic     v1_reg;
    logic     v2_reg;
    logic     m_valid_reg;
    p2rgb_pkg::pix_tag_t tag1_reg;
    logic     end2_reg;

    // Stage 1 channel values and stage 2 copies for the non-blended paths.
    logic [7:0] r1;
    logic [7:0] g1;
    logic [7:0] b1;
    logic [7:0] a1;
    logic [7:0] r2_reg;
    logic [7:0] g2_reg;
    logic [7:0] b2_reg;
    logic [7:0] r_blend;
    logic [7:0] g_blend;
    logic [7:0] b_blend;

    // The pipeline moves as one whenever the output register can take a pixel.
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign m_valid   = m_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg    <= p2rgb_pkg::FORMAT_RESET;
            count_reg     <= p2rgb_pkg::COUNT_RESET;
            row_width_reg <= p2rgb_pkg::ROW_WIDTH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                p2rgb_pkg::REG_COMPONENT_FORMAT: format_reg    <= cfg_data[0];
                p2rgb_pkg::REG_COMP_COUNT:       count_reg     <= cfg_data[2:0];
                p2rgb_pkg::REG_ROW_WIDTH:        row_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A row ends when the column equals row_width - 1 in 16 bits, so a zero
    // width gives rows of 65536 pixels. Otherwise the column simply wraps.
    assign last_col   = row_width_reg - 16'd1;
    assign at_row_end = (column_reg == last_col);

    always_comb begin
        column_next = column_reg;
        parity_next = parity_reg;
        if (s_valid && adv) begin
            if (at_row_end) begin
                column_next = '0;
                parity_next = !parity_reg;
            end else begin
                column_next = column_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg  <= '0;
            parity_reg  <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            column_reg <= column_next;
            parity_reg <= parity_next;
            if (adv) begin
                v1_reg      <= s_valid;
                v2_reg      <= v1_reg;
                m_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag1_reg.parity  <= column_reg[0] ^ parity_reg;
            tag1_reg.row_end <= at_row_end;
            end2_reg         <= tag1_reg.row_end;
            r2_reg           <= r1;
            g2_reg           <= g1;
            b2_reg           <= b1;
        end
    end

    // Stage 1: one scale lane per component.
    p2rgb_scale_lane u_scale_r (
        .aclk     (aclk),
        .en       (adv),
        .wide_fmt (format_reg),
        .comp     (s_data.comp0),
        .chan_reg (r1)
    );

    p2rgb_scale_lane u_scale_g (
        .aclk     (aclk),
        .en       (adv),
        .wide_fmt (format_reg),
        .comp     (s_data.comp1),
        .chan_reg (g1)
    );

    p2rgb_scale_lane u_scale_b (
        .aclk     (aclk),
        .en       (adv),
        .wide_fmt (format_reg),
        .comp     (s_data.comp2),
        .chan_reg (b1)
    );

    p2rgb_scale_lane u_scale_a (
        .aclk     (aclk),
        .en       (adv),
        .wide_fmt (format_reg),
        .comp     (s_data.comp3),
        .chan_reg (a1)
    );

    // Stages 2 and 3: one blend lane per color, each with its own weight.
    p2rgb_blend_lane u_blend_r (
        .aclk   (aclk),
        .en     (adv),
        .weight (p2rgb_pkg::K_RED),
        .chan   (r1),
        .alpha  (a1),
        .parity (tag1_reg.parity),
        .blend  (r_blend)
    );

    p2rgb_blend_lane u_blend_g (
        .aclk   (aclk),
        .en     (adv),
        .weight (p2rgb_pkg::K_GREEN),
        .chan   (g1),
        .alpha  (a1),
        .parity (tag1_reg.parity),
        .blend  (g_blend)
    );

    p2rgb_blend_lane u_blend_b (
        .aclk   (aclk),
        .en     (adv),
        .weight (p2rgb_pkg::K_BLUE),
        .chan   (b1),
        .alpha  (a1),
        .parity (tag1_reg.parity),
        .blend  (b_blend)
    );

    // Merge: pick the path for the configured component count and register it.
    p2rgb_merge u_merge (
        .aclk        (aclk),
        .en          (adv),
        .count       (count_reg),
        .red         (r2_reg),
        .green       (g2_reg),
        .blue        (b2_reg),
        .red_blend   (r_blend),
        .green_blend (g_blend),
        .blue_blend  (b_blend),
        .row_end     (end2_reg),
        .pix_reg     (m_data)
    );

endmodule

>>> src/p2rgb_scale_lane.sv
module p2rgb_scale_lane (
    input  logic        aclk,
    input  logic        en,
    input  logic        wide_fmt,
    input  logic [15:0] comp,
    output logic [7:0]  chan_reg
);

    logic [32:0] prod;
    logic [7:0]  chan_next;

    // A 16-bit value scaled by 255/65535 is the value divided by 257.
    assign prod = {17'd0, comp} * {16'd0, p2rgb_pkg::RECIP_257};

    always_comb begin
        if (wide_fmt) begin
            chan_next = prod[31:24];
        end else begin
            chan_next = comp[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chan_reg <= chan_next;
        end
    end

endmodule

>>> src/p2rgb_blend_lane.sv
module p2rgb_blend_lane (
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] weight,
    input  logic [7:0]  chan,
    input  logic [7:0]  alpha,
    input  logic        parity,
    output logic [7:0]  blend
);

    logic [7:0]  inv_alpha;
    logic [15:0] inv_scaled;
    logic [15:0] color_prod;
    logic [31:0] board_prod;
    logic [16:0] sum_next;
    logic [16:0] sum_reg;
    logic [34:0] quot_prod;

    // The numerator divided by 2^17 is c*a plus the truncated checker term,
    // since c*a*2^17 contributes no fraction.
    assign inv_alpha  = 8'd255 - alpha;
    assign inv_scaled = {inv_alpha, 8'd0} - {8'd0, inv_alpha};
    assign color_prod = {8'd0, chan} * {8'd0, alpha};
    assign board_prod = {16'd0, inv_scaled} * {16'd0, weight};

    always_comb begin
        if (parity) begin
            sum_next = {1'b0, color_prod} + {2'd0, board_prod[31:17]};
        end else begin
            sum_next = {1'b0, color_prod};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    // Division by 255 of the registered sum.
    assign quot_prod = {18'd0, sum_reg} * {17'd0, p2rgb_pkg::RECIP_255};
    assign blend     = quot_prod[32:25];

endmodule

>>> src/p2rgb_merge.sv
module p2rgb_merge (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [2:0]           count,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  logic [7:0]           red_blend,
    input  logic [7:0]           green_blend,
    input  logic [7:0]           blue_blend,
    input  logic                 row_end,
    output p2rgb_pkg::pix_out_t  pix_reg
);

    p2rgb_pkg::pix_out_t pix_next;

    always_comb begin
        pix_next.row_end = row_end;
        unique case (count)
            p2rgb_pkg::COUNT_GREY: begin
                pix_next.red_out   = red;
                pix_next.green_out = red;
                pix_next.blue_out  = red;
            end
            p2rgb_pkg::COUNT_RG: begin
                pix_next.red_out   = red;
                pix_next.green_out = green;
                pix_next.blue_out  = 8'd255;
            end
            p2rgb_pkg::COUNT_RGBA: begin
                pix_next.red_out   = red_blend;
                pix_next.green_out = green_blend;
                pix_next.blue_out  = blue_blend;
            end
            default: begin
                pix_next.red_out   = red;
                pix_next.green_out = green;
                pix_next.blue_out  = blue;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg <= pix_next;
        end
    end

endmodule

>>> sim/pixel_checker.sv
`timescale 1ns / 100ps

module pixel_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  p2rgb_pkg::pix_in_t   s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  p2rgb_pkg::pix_out_t  m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output int unsigned          mismatch_count,
    output int unsigned          pending_count
);

    localparam int unsigned PrintLimit = 50;

    // Shadow copy of the configuration and of the checkerboard position.
    logic        fmt_16;
    logic [2:0]  comp_count;
    logic [15:0] row_len;
    logic [15:0] col;
    logic        row_odd;

    p2rgb_pkg::pix_out_t rgb_pending_q[$];
    int unsigned errors = 0;

    assign mismatch_count = errors;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PrintLimit) begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
        errors++;
    endtask

    function automatic logic [7:0] narrow(input logic wide, input logic [15:0] v);
        logic [31:0] scaled;
        scaled = (32'(v) * 32'd255) / 32'd65535;
        return wide ? scaled[7:0] : v[7:0];
    endfunction

    // Exact composite over the checkerboard, formed as one fraction and truncated.
    function automatic logic [7:0] over_checker(input logic [7:0] c, input logic [7:0] a,
                                                input logic tile, input logic [15:0] k);
        logic [63:0] num;
        logic [63:0] q;
        num = 64'(c) * 64'(a) * 64'd131072
            + 64'd255 * 64'(8'd255 - a) * 64'(tile) * 64'(k);
        q = num / (64'd255 * 64'd131072);
        return (q > 64'd255) ? 8'hFF : q[7:0];
    endfunction

    function automatic p2rgb_pkg::pix_out_t convert_pixel(input p2rgb_pkg::pix_in_t px);
        p2rgb_pkg::pix_out_t o;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       tile;
        r = narrow(fmt_16, px.comp0);
        g = narrow(fmt_16, px.comp1);
        b = narrow(fmt_16, px.comp2);
        a = narrow(fmt_16, px.comp3);
        tile = col[0] ^ row_odd;
        o.red_out   = r;
        o.green_out = g;
        o.blue_out  = b;
        case (comp_count)
            p2rgb_pkg::COUNT_GREY: begin
                o.green_out = r;
                o.blue_out  = r;
            end
            p2rgb_pkg::COUNT_RG: begin
                o.blue_out = 8'hFF;
            end
            p2rgb_pkg::COUNT_RGBA: begin
                o.red_out   = over_checker(r, a, tile, p2rgb_pkg::K_RED);
                o.green_out = over_checker(g, a, tile, p2rgb_pkg::K_GREEN);
                o.blue_out  = over_checker(b, a, tile, p2rgb_pkg::K_BLUE);
            end
            default: begin
            end
        endcase
        o.row_end = (col == row_len - 16'd1);
        return o;
    endfunction

    always @(posedge aclk) begin
        p2rgb_pkg::pix_out_t want;
        if (!aresetn) begin
            fmt_16     = p2rgb_pkg::FORMAT_RESET;
            comp_count = p2rgb_pkg::COUNT_RESET;
            row_len    = p2rgb_pkg::ROW_WIDTH_RESET;
            col        = '0;
            row_odd    = 1'b0;
            rgb_pending_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    p2rgb_pkg::REG_COMPONENT_FORMAT: fmt_16 = cfg_data[0];
                    p2rgb_pkg::REG_COMP_COUNT:       comp_count = cfg_data[2:0];
                    p2rgb_pkg::REG_ROW_WIDTH:        row_len = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                want = convert_pixel(s_data);
                rgb_pending_q.push_back(want);
                if (want.row_end) begin
                    col     = '0;
                    row_odd = ~row_odd;
                end else begin
                    col = col + 16'd1;
                end
            end
            if (m_valid && m_ready) begin
                if (rgb_pending_q.size() == 0) begin
                    report_mismatch("result with no pixel pending", 1, 0);
                end else begin
                    want = rgb_pending_q.pop_front();
                    if (m_data.red_out != want.red_out)
                        report_mismatch("red_out", m_data.red_out, want.red_out);
                    if (m_data.green_out != want.green_out)
                        report_mismatch("green_out", m_data.green_out, want.green_out);
                    if (m_data.blue_out != want.blue_out)
                        report_mismatch("blue_out", m_data.blue_out, want.blue_out);
                    if (m_data.row_end != want.row_end)
                        report_mismatch("row_end", m_data.row_end, want.row_end);
                end
            end
        end
        pending_count <= rgb_pending_q.size();
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the pixel to RGB8 converter. The checker instance
// beside the block watches all three channels, predicts every result and
// counts mismatches; this module only makes requests, stalls the result side
// and decides the outcome.
module tb_top;

    // An idle stretch in a correct run is a few sender gaps, receiver stalls
    // and the pipeline fill; this limit is many times that.
    localparam int unsigned IdleLimit   = 200;
    // Cycles allowed after the last result for anything stray to show up.
    localparam int unsigned SettleCycles = 8;

    localparam logic       FMT_8BIT   = 1'b0;
    localparam logic       FMT_16BIT  = 1'b1;
    localparam logic [2:0] COUNT_ZERO = 3'd0;
    localparam logic [2:0] COUNT_MAX  = 3'd7;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    p2rgb_pkg::pix_in_t  s_data = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    p2rgb_pkg::pix_out_t m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned idle_cycles  = 0;
    int unsigned pixels_sent  = 0;
    int unsigned setups_done  = 0;

    // When set, neither side inserts gaps, so the block runs at full rate.
    logic        calm = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pixel_to_rgb8_with_checker_alpha DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pixel_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Watchdog: any accepted request on any channel restarts the count. A
    // hung pipeline or a lost result leaves the count running to the limit.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IdleLimit) begin
            $display("Timeout after %0d cycles without a request", IdleLimit);
            $display("pixel_to_rgb8_with_checker_alpha verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: before each result the receiver holds ready low for a random
    // stall, none when calm; a zero draw keeps ready high for back-to-back results.
    initial begin : result_sink
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // One pixel request: an optional gap, then valid held with a steady
    // payload until the block takes it. Valid is left high so the next call
    // can follow without a bubble.
    task automatic send_pixel(input p2rgb_pkg::pix_in_t px);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pixels_sent++;
    endtask

    // Stop sending and wait until every predicted result has been returned.
    // Every pixel yields a result, so an empty prediction store means idle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so consecutive register writes need no bubble.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Reconfigure only once the pipeline is empty. Half the time the unused
    // upper bits of the narrow registers carry junk, which must be masked off,
    // and now and then a write goes to the unassigned index.
    task automatic apply_setup(input logic fmt, input logic [2:0] cnt, input logic [15:0] wid);
        logic [15:0] noise;
        drain();
        noise = $urandom_range(0, 1) ? 16'($urandom) : 16'h0000;
        write_reg(p2rgb_pkg::REG_COMPONENT_FORMAT, {noise[15:1], fmt});
        write_reg(p2rgb_pkg::REG_COMP_COUNT, {noise[15:3], cnt});
        write_reg(p2rgb_pkg::REG_ROW_WIDTH, wid);
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
        setups_done++;
    endtask

    // Components lean toward the edges of the 8- and 16-bit ranges.
    function automatic logic [15:0] random_comp();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h00FF;
            3: return 16'hFF00;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic p2rgb_pkg::pix_in_t random_pixel();
        p2rgb_pkg::pix_in_t px;
        px.comp0 = random_comp();
        px.comp1 = random_comp();
        px.comp2 = random_comp();
        px.comp3 = random_comp();
        return px;
    endfunction

    initial begin : stimulus
        logic        fmt;
        logic [2:0]  cnt;
        logic [15:0] wid;
        int unsigned burst;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: 8-bit, three components, one pixel per row, so
        // every pixel ends a row and the row parity flips each time.
        send_pixel(p2rgb_pkg::pix_in_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_pixel(p2rgb_pkg::pix_in_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_pixel(p2rgb_pkg::pix_in_t'{16'h12AB, 16'h34CD, 16'h56EF, 16'h0000});

        // 16-bit RGBA over two rows of three: transparent pixels on both
        // checker squares, fully opaque, half alpha and an almost clear one.
        apply_setup(FMT_16BIT, p2rgb_pkg::COUNT_RGBA, 16'd3);
        send_pixel(p2rgb_pkg::pix_in_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000});
        send_pixel(p2rgb_pkg::pix_in_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_pixel(p2rgb_pkg::pix_in_t'{16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF});
        send_pixel(p2rgb_pkg::pix_in_t'{16'h1234, 16'h5678, 16'h9ABC, 16'h8000});
        send_pixel(p2rgb_pkg::pix_in_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_pixel(p2rgb_pkg::pix_in_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0101});

        // 8-bit RGBA with junk in the upper bytes, which must be ignored.
        apply_setup(FMT_8BIT, p2rgb_pkg::COUNT_RGBA, 16'd2);
        send_pixel(p2rgb_pkg::pix_in_t'{16'hFFFF, 16'hFF00, 16'h00FF, 16'hFF80});
        send_pixel(p2rgb_pkg::pix_in_t'{16'h00FF, 16'h0000, 16'h0080, 16'h0000});

        // Grey: only the first component matters.
        apply_setup(FMT_8BIT, p2rgb_pkg::COUNT_GREY, 16'd2);
        send_pixel(p2rgb_pkg::pix_in_t'{16'hABFF, 16'h1234, 16'h5678, 16'h9ABC});
        send_pixel(p2rgb_pkg::pix_in_t'{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF});

        // Red and green with blue forced full, on a row of 65535 pixels.
        apply_setup(FMT_16BIT, p2rgb_pkg::COUNT_RG, 16'hFFFF);
        send_pixel(p2rgb_pkg::pix_in_t'{16'hFFFF, 16'h0000, 16'h1234, 16'h5678});
        send_pixel(p2rgb_pkg::pix_in_t'{16'h0101, 16'hFEFF, 16'hFFFF, 16'hFFFF});

        // Out-of-range counts fall back to plain RGB.
        apply_setup(FMT_16BIT, COUNT_ZERO, 16'd4);
        send_pixel(p2rgb_pkg::pix_in_t'{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000});
        apply_setup(FMT_8BIT, COUNT_MAX, 16'd4);
        send_pixel(p2rgb_pkg::pix_in_t'{16'h00FF, 16'h0080, 16'h0001, 16'h00FF});

        // A zero width means a 65536-pixel row.
        apply_setup(FMT_16BIT, p2rgb_pkg::COUNT_RGBA, 16'd0);
        send_pixel(p2rgb_pkg::pix_in_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF});
        send_pixel(p2rgb_pkg::pix_in_t'{16'h0000, 16'h0000, 16'h0000, 16'h8000});

        // Random phases. Each one pauses the sender until the pipeline is
        // empty, picks a new setup and sends a burst. Counts lean toward the
        // four legal values; widths are mostly short so rows end often, with
        // the extremes forced in the first two phases. About one phase in
        // four runs at full rate on both sides.
        for (int ph = 0; ph < 16; ph++) begin
            fmt = 1'($urandom);
            cnt = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(1, 4));
            if (ph == 0) begin
                wid = 16'hFFFF;
            end else if (ph == 1) begin
                wid = 16'd1;
            end else begin
                case ($urandom_range(0, 9))
                    0: wid = 16'($urandom);
                    1: wid = 16'd0;
                    default: wid = 16'($urandom_range(1, 12));
                endcase
            end
            apply_setup(fmt, cnt, wid);
            calm = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(50, 105);
            repeat (burst) send_pixel(random_pixel());
        end
        calm = 1'b0;

        drain();
        repeat (SettleCycles) @(posedge aclk);

        $display("Run covered %0d pixel requests under %0d register setups,", pixels_sent,
                 setups_done);
        $display("both component widths, all counts with fallbacks, short and zero widths.");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("pixel_to_rgb8_with_checker_alpha verification clean");
        end else begin
            $display("pixel_to_rgb8_with_checker_alpha verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/p2rgb_pkg.sv
src/p2rgb_scale_lane.sv
src/p2rgb_blend_lane.sv
src/p2rgb_merge.sv
src/pixel_to_rgb8_with_checker_alpha.sv
sim/pixel_checker.sv
sim/tb_top.sv
